// ===== hdl/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfa_pkg
// types, codes and defaults shared by the frame allocator modules
// ----------------------------------------------------------------------------
package bfa_pkg;

	// default sizing
	localparam int DEF_MAX_FRAMES       = 1024;
	localparam int DEF_BITMAP_WORD_BITS = 32;
	localparam int DEF_PAGE_BYTES       = 4096;

	// width used for all frame number compares (covers the largest frame count)
	localparam int CMP_W = 21;

	// register width and reset value fixed by the interface
	localparam int FC_W   = 11;
	localparam int FC_RST = 1024;

	// command codes
	localparam logic [2:0] CMD_ALLOC     = 3'd0;
	localparam logic [2:0] CMD_FREE      = 3'd1;
	localparam logic [2:0] CMD_TEST      = 3'd2;
	localparam logic [2:0] CMD_MARK_USED = 3'd3;
	localparam logic [2:0] CMD_MARK_FREE = 3'd4;

	// status codes
	localparam logic [1:0] STAT_DONE   = 2'd0;
	localparam logic [1:0] STAT_NOP    = 2'd1;
	localparam logic [1:0] STAT_NOFREE = 2'd2;
	localparam logic [1:0] STAT_RANGE  = 2'd3;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [21:0] phys_addr;
		logic [9:0]  page_frame;
		logic        kernel_page;
		logic        write_ok;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [9:0] frame_number;
		logic       present;
		logic       read_write;
		logic       user_mode;
		logic       frame_in_use;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_MODIFY,
		S_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_item;
		logic cfg_we;
		logic dec;
		logic scan_run;
		logic modify;
		logic load_out;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_scan;
		logic need_rmw;
		logic scan_done;
		logic out_free;
	} dp_sts_t;

endpackage

// ===== hdl/bfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfa_ctrl
// sequencer: one word at a time through decode, bitmap scan or read-modify-write
// ----------------------------------------------------------------------------
module bfa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	output bfa_pkg::dp_cmd_t  cmd,
	input  bfa_pkg::dp_sts_t  sts
);
	import bfa_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				if (sts.need_scan)     state_d = S_SCAN;
				else if (sts.need_rmw) state_d = S_MODIFY;
				else                   state_d = S_FINISH;
			end
			S_SCAN: begin
				if (sts.scan_done) state_d = S_FINISH;
			end
			S_MODIFY: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		cfg_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_stall     = 1'b0;
				cfg_ready     = 1'b1;
				cmd.load_item = req_valid;
				cmd.cfg_we    = cfg_valid;
			end
			S_DECODE: cmd.dec      = 1'b1;
			S_SCAN:   cmd.scan_run = 1'b1;
			S_MODIFY: cmd.modify   = 1'b1;
			S_FINISH: cmd.load_out = sts.out_free;
			default: ;
		endcase
	end

endmodule

// ===== hdl/bfa_dp.sv =====
// ----------------------------------------------------------------------------
// bfa_dp
// bitmap store, first-fit word scan, read-modify-write and result registers
// ----------------------------------------------------------------------------
module bfa_dp #(
	parameter int MAX_FRAMES       = bfa_pkg::DEF_MAX_FRAMES,
	parameter int BITMAP_WORD_BITS = bfa_pkg::DEF_BITMAP_WORD_BITS,
	parameter int PAGE_BYTES       = bfa_pkg::DEF_PAGE_BYTES
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bfa_pkg::req_t             req,
	input  logic [bfa_pkg::FC_W-1:0]  cfg_frame_count,
	input  logic                      rsp_stall,
	output logic                      rsp_valid,
	output bfa_pkg::rsp_t             rsp,
	input  bfa_pkg::dp_cmd_t          cmd,
	output bfa_pkg::dp_sts_t          sts
);
	import bfa_pkg::*;

	// word size and page size are to be powers of two; the block itself does not check this
	localparam int WB         = BITMAP_WORD_BITS;
	localparam int WORD_COUNT = (MAX_FRAMES + WB - 1) / WB;
	localparam int WA_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int BIT_W      = $clog2(WB);
	localparam int PAGE_SH    = $clog2(PAGE_BYTES);

	localparam logic [CMP_W-1:0] MAXF      = CMP_W'(MAX_FRAMES);
	localparam logic [WA_W:0]    WCNT      = (WA_W + 1)'(WORD_COUNT);
	localparam logic [WA_W-1:0]  LAST_WORD = WA_W'(WORD_COUNT - 1);

	// registers
	req_t                  item_q;
	logic [FC_W-1:0]       fc_q;
	rsp_t                  res_q, res_d;
	rsp_t                  rsp_q;
	logic                  rsp_valid_q;
	logic [WB-1:0]         mem [0:WORD_COUNT-1];
	logic [WORD_COUNT-1:0] vld_q;
	logic [WB-1:0]         rd_word_s1;
	logic                  rd_live_s1;
	logic [WA_W:0]         scan_ptr_q;
	logic                  chk_s1;
	logic [WA_W-1:0]       chk_word_s1;

	// combinational
	logic [CMP_W-1:0] lim_c, fc_ext_c, tgt_c, base_c, cand_c;
	logic             in_rng_c;
	logic [WA_W-1:0]  tgt_word_c, rd_addr_c, wa_c;
	logic [BIT_W-1:0] tgt_bit_c, low_c;
	logic [WB-1:0]    word_c, tgt_mask_c, wd_c;
	logic             free_any_c, found_c, nofree_c, we_c, issue_c;
	logic             is_free_c, is_mark_c, is_test_c;

	// frame limit and target frame
	always_comb begin
		fc_ext_c   = CMP_W'(fc_q);
		lim_c      = (fc_ext_c < MAXF) ? fc_ext_c : MAXF;
		is_free_c  = (item_q.cmd == CMD_FREE);
		is_test_c  = (item_q.cmd == CMD_TEST);
		is_mark_c  = (item_q.cmd == CMD_MARK_USED) || (item_q.cmd == CMD_MARK_FREE);
		tgt_c      = is_free_c ? CMP_W'(item_q.page_frame)
		                       : CMP_W'(item_q.phys_addr >> PAGE_SH);
		in_rng_c   = (tgt_c < lim_c);
		tgt_word_c = tgt_c[BIT_W +: WA_W];
		tgt_bit_c  = tgt_c[BIT_W-1:0];
		tgt_mask_c = WB'(1) << tgt_bit_c;
		word_c     = rd_live_s1 ? rd_word_s1 : '0;
	end

	// first-fit check of the word in hand
	always_comb begin
		low_c = '0;
		for (int i = WB - 1; i >= 0; i--) begin
			if (!word_c[i]) low_c = BIT_W'(i);
		end
		free_any_c = ~&word_c;
		base_c     = CMP_W'(chk_word_s1) << BIT_W;
		cand_c     = base_c + CMP_W'(low_c);
		found_c    = chk_s1 && (base_c < lim_c) && free_any_c && (cand_c < lim_c);
		nofree_c   = chk_s1 && ((base_c >= lim_c) || (free_any_c && (cand_c >= lim_c))
		             || (!free_any_c && (chk_word_s1 == LAST_WORD)));
	end

	always_comb begin
		sts.need_scan = (item_q.cmd == CMD_ALLOC) && (item_q.page_frame == '0);
		sts.need_rmw  = ((is_free_c && (item_q.page_frame != '0)) || is_test_c || is_mark_c)
		                && in_rng_c;
		sts.scan_done = found_c || nofree_c;
		sts.out_free  = !rsp_valid_q || !rsp_stall;
	end

	// store port selection
	always_comb begin
		issue_c   = cmd.scan_run && (scan_ptr_q < WCNT);
		rd_addr_c = cmd.scan_run ? scan_ptr_q[WA_W-1:0] : tgt_word_c;
		if (cmd.scan_run) begin
			we_c = found_c;
			wa_c = chk_word_s1;
			wd_c = word_c | (WB'(1) << low_c);
		end else begin
			we_c = cmd.modify && !is_test_c;
			wa_c = tgt_word_c;
			wd_c = (item_q.cmd == CMD_MARK_USED) ? (word_c | tgt_mask_c)
			                                     : (word_c & ~tgt_mask_c);
		end
	end

	// result building
	always_comb begin
		res_d = res_q;
		if (cmd.dec) begin
			res_d = '0;
			unique case (item_q.cmd) inside
				CMD_ALLOC: begin
					res_d.status       = STAT_NOP;
					res_d.frame_number = item_q.page_frame;
				end
				CMD_FREE: begin
					if (item_q.page_frame == '0) begin
						res_d.status = STAT_NOP;
					end else begin
						res_d.status       = STAT_RANGE;
						res_d.frame_number = item_q.page_frame;
					end
				end
				CMD_TEST, CMD_MARK_USED, CMD_MARK_FREE: res_d.status = STAT_RANGE;
				default: res_d.status = STAT_NOP;
			endcase
		end
		if (cmd.scan_run && sts.scan_done) begin
			res_d = '0;
			if (found_c) begin
				res_d.status       = STAT_DONE;
				res_d.frame_number = cand_c[9:0];
				res_d.present      = 1'b1;
				res_d.read_write   = item_q.write_ok;
				res_d.user_mode    = ~item_q.kernel_page;
			end else begin
				res_d.status = STAT_NOFREE;
			end
		end
		if (cmd.modify) begin
			res_d              = '0;
			res_d.status       = STAT_DONE;
			res_d.frame_in_use = is_test_c && word_c[tgt_bit_c];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q        <= FC_W'(FC_RST);
			rsp_valid_q <= 1'b0;
			vld_q       <= '0;
			scan_ptr_q  <= '0;
			chk_s1      <= 1'b0;
		end else begin
			if (cmd.cfg_we) fc_q <= cfg_frame_count;
			if (cmd.load_out)    rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
			if (we_c) vld_q[wa_c] <= 1'b1;
			if (cmd.dec)           scan_ptr_q <= '0;
			else if (issue_c)      scan_ptr_q <= scan_ptr_q + 1'b1;
			chk_s1 <= issue_c;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_item) item_q <= req;
		if (cmd.load_out)  rsp_q  <= res_q;
		res_q       <= res_d;
		chk_word_s1 <= scan_ptr_q[WA_W-1:0];
	end

	// bitmap store, registered read
	always_ff @(posedge clk) begin
		if (we_c) mem[wa_c] <= wd_c;
		rd_word_s1 <= mem[rd_addr_c];
		rd_live_s1 <= vld_q[rd_addr_c];
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== hdl/bitmap_frame_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// first-fit physical frame allocator over a bitmap of usage words
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | word
//  ---------+------------------------+-------------------------------
//  req      | req_valid / req_stall  | command, address, page entry
//  rsp      | rsp_valid / rsp_stall  | status, frame and page bits
//  cfg      | cfg_valid / cfg_ready  | frame_count
//
//  one word is worked on at a time: accept, decode, then either
//  a first-fit scan from bitmap word 0, a read-modify-write or nothing,
//  then a load of the output register; the single-read store port
//  sets the scan at one bitmap word per cycle
//  reset clears the bitmap at once through one valid flag per word
//  a stalled result waits in the output register; the next word is taken
//  meanwhile and holds in its last step until the register frees
//
module bitmap_frame_allocator #(
	parameter int MAX_FRAMES       = bfa_pkg::DEF_MAX_FRAMES,
	parameter int BITMAP_WORD_BITS = bfa_pkg::DEF_BITMAP_WORD_BITS,
	parameter int PAGE_BYTES       = bfa_pkg::DEF_PAGE_BYTES
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// request channel
	input  logic                      req_valid,
	output logic                      req_stall,
	input  bfa_pkg::req_t             req,
	// result channel
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output bfa_pkg::rsp_t             rsp,
	// frame_count register write
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [bfa_pkg::FC_W-1:0]  cfg_frame_count
);
	import bfa_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencer: decides which step runs, nothing of the payload
	bfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// bitmap, limit register, scan pointer and result path
	bfa_dp #(
		.MAX_FRAMES       (MAX_FRAMES),
		.BITMAP_WORD_BITS (BITMAP_WORD_BITS),
		.PAGE_BYTES       (PAGE_BYTES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req),
		.cfg_frame_count (cfg_frame_count),
		.rsp_stall       (rsp_stall),
		.rsp_valid       (rsp_valid),
		.rsp             (rsp),
		.cmd             (cmd),
		.sts             (sts)
	);

endmodule

// ===== hdl/bfa_checker.sv =====
// ----------------------------------------------------------------------------
// bfa_checker
// port-level checks on the frame allocator, bound to the top level
// ----------------------------------------------------------------------------
module bfa_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      req_valid,
	input logic                      req_stall,
	input logic                      rsp_valid,
	input logic                      rsp_stall,
	input bfa_pkg::rsp_t             rsp,
	input logic                      cfg_ready
);
	import bfa_pkg::*;

	// one word in flight: taking a word closes the request side
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request taken while a word is in flight");

	// register writes only while no word is in flight
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready != req_stall)
		else $error("config port open while busy");

	// a result needs at least decode and finish
	a_no_early_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> !$rose(rsp_valid))
		else $error("result raised straight after accept");

	// stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
		else $error("stalled result changed");

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the first-fit bitmap frame allocator
// ----------------------------------------------------------------------------
//
//  a short scripted run covers alloc, free, test, both mark commands, two
//  undefined codes, and the corner cases: echoed page entries, an empty pool,
//  addresses and frames past the limit, a zero limit and a saturated one
//  it is followed by random command words in several frame_count phases,
//  each phase under one of four idling patterns on the request and result sides
//  every accepted word is run through a shadow allocator here and its scripted
//  or shadow outcome queued; each result word is compared field by field in order
//
module tb_top;

	import bfa_pkg::*;

	localparam int CLK_HALF        = 5;
	localparam int RESET_CYCLES    = 6;
	localparam int SETTLE_CYCLES   = 40;   // longer than the slowest alloc
	localparam int CYCLE_LIMIT     = 1_000_000;
	localparam int N_PHASES        = 8;
	localparam int WORDS_PER_PHASE = 175;

	// frame_count per random phase: partial words, one exact word,
	// a single frame, the reset value and the saturated top
	localparam logic [FC_W-1:0] PHASE_FRAMES [N_PHASES] =
		'{11'd40, 11'd33, 11'd1024, 11'd64, 11'd2047, 11'd32, 11'd1, 11'd31};

	typedef enum bit {ROW_WORD, ROW_CFG} row_kind_t;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct {
		row_kind_t       kind;
		req_t            w;
		logic [FC_W-1:0] frame_count;
		bit              typed;   // outcome written into the script
		rsp_t            want;
	} script_row_t;

	// ------------------------------------------------------------------
	// dut hookup
	// ------------------------------------------------------------------
	logic            clk             = 1'b0;
	logic            arst_n          = 1'b0;
	logic            req_valid       = 1'b0;
	logic            req_stall;
	req_t            req             = '0;
	logic            rsp_valid;
	logic            rsp_stall       = 1'b0;
	rsp_t            rsp;
	logic            cfg_valid       = 1'b0;
	logic            cfg_ready;
	logic [FC_W-1:0] cfg_frame_count = '0;

	bitmap_frame_allocator dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.req             (req),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.rsp             (rsp),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_frame_count (cfg_frame_count)
	);

	always #(CLK_HALF) clk = ~clk;

	// ------------------------------------------------------------------
	// shadow allocator state
	// ------------------------------------------------------------------
	bit [DEF_MAX_FRAMES-1:0] frame_used     = '0;      // clear, like the bitmap after reset
	logic [FC_W-1:0]         managed_frames = FC_W'(FC_RST);
	rsp_t                    outcome_q [$];

	int fail_count      = 0;
	int cycle_count     = 0;
	int sender_idle_pct = 0;
	int rsp_stall_pct   = 0;
	int n_words         = 0;
	int n_taken         = 0;
	int n_pool_empty    = 0;
	int n_out_of_range  = 0;
	int n_settings      = 1;

	// frame_count above the bitmap size saturates
	function automatic int frame_limit();
		return (managed_frames > DEF_MAX_FRAMES) ? DEF_MAX_FRAMES : int'(managed_frames);
	endfunction

	// applies one command word to the shadow bitmap and returns its result word
	function automatic rsp_t apply_command(req_t w);
		rsp_t o;
		int   lim;
		int   f;
		int   addr_frame;
		o          = '0;
		lim        = frame_limit();
		addr_frame = int'(w.phys_addr / DEF_PAGE_BYTES);
		case (w.cmd) inside
			CMD_ALLOC: begin
				if (w.page_frame != '0) begin
					// entry already mapped: echo it, touch nothing
					o.status       = STAT_NOP;
					o.frame_number = w.page_frame;
				end else begin
					// first fit: lowest clear bit below the limit
					f = 0;
					while (f < lim && frame_used[f])
						f++;
					if (f >= lim) begin
						o.status = STAT_NOFREE;
					end else begin
						frame_used[f]  = 1'b1;
						o.status       = STAT_DONE;
						o.frame_number = 10'(f);
						o.present      = 1'b1;
						o.read_write   = w.write_ok;
						o.user_mode    = ~w.kernel_page;
					end
				end
			end
			CMD_FREE: begin
				if (w.page_frame == '0) begin
					o.status = STAT_NOP;
				end else if (int'(w.page_frame) >= lim) begin
					o.status       = STAT_RANGE;
					o.frame_number = w.page_frame;
				end else begin
					frame_used[w.page_frame] = 1'b0;
					o.status                 = STAT_DONE;
				end
			end
			CMD_TEST, CMD_MARK_USED, CMD_MARK_FREE: begin
				if (addr_frame >= lim)
					o.status = STAT_RANGE;
				else if (w.cmd == CMD_TEST)
					o.frame_in_use = frame_used[addr_frame];
				else
					frame_used[addr_frame] = (w.cmd == CMD_MARK_USED);
			end
			default: begin
				o.status = STAT_NOP;
			end
		endcase
		return o;
	endfunction

	// ------------------------------------------------------------------
	// script helpers
	// ------------------------------------------------------------------
	function automatic rsp_t outcome(logic [1:0] st, logic [9:0] fn, bit p, bit rw,
					 bit um, bit iu);
		rsp_t o;
		o.status       = st;
		o.frame_number = fn;
		o.present      = p;
		o.read_write   = rw;
		o.user_mode    = um;
		o.frame_in_use = iu;
		return o;
	endfunction

	function automatic script_row_t word_row(logic [2:0] c, logic [21:0] a, logic [9:0] pf,
						 bit k, bit wr, bit typed, rsp_t want);
		script_row_t r;
		r.kind             = ROW_WORD;
		r.w.cmd            = c;
		r.w.phys_addr      = a;
		r.w.page_frame     = pf;
		r.w.kernel_page    = k;
		r.w.write_ok       = wr;
		r.frame_count      = '0;
		r.typed            = typed;
		r.want             = want;
		return r;
	endfunction

	function automatic script_row_t cfg_row(logic [FC_W-1:0] v);
		script_row_t r;
		r.kind        = ROW_CFG;
		r.w           = '0;
		r.frame_count = v;
		r.typed       = 1'b0;
		r.want        = '0;
		return r;
	endfunction

	// random command word; mostly sensible commands aimed inside the
	// managed range, the rest arbitrary bits including undefined codes
	function automatic req_t random_word();
		req_t w;
		int   pick;
		int   lim;
		lim             = frame_limit();
		w.cmd           = 3'($urandom);
		w.phys_addr     = 22'($urandom);
		w.page_frame    = 10'($urandom);
		w.kernel_page   = 1'($urandom);
		w.write_ok      = 1'($urandom);
		pick            = $urandom_range(99);
		if (pick < 45) begin
			w.cmd = CMD_ALLOC;
			if ($urandom_range(9) != 0)
				w.page_frame = '0;
		end else if (pick < 65) begin
			w.cmd = CMD_FREE;
			if (lim > 0 && $urandom_range(4) != 0)
				w.page_frame = 10'($urandom_range(lim - 1));
		end else if (pick < 95) begin
			w.cmd = (pick < 75) ? CMD_TEST : (pick < 85) ? CMD_MARK_USED : CMD_MARK_FREE;
			if (lim > 0 && $urandom_range(4) != 0)
				w.phys_addr[21:12] = 10'($urandom_range(lim - 1));
		end
		return w;
	endfunction

	// ------------------------------------------------------------------
	// request side
	// ------------------------------------------------------------------
	// offers one word, holds it until taken, then queues its outcome;
	// valid stays high afterwards so back-to-back words need no gap
	task automatic send_word(req_t w, bit typed, rsp_t want);
		int   gap;
		rsp_t predicted;
		gap = 0;
		while ($urandom_range(99) < sender_idle_pct)
			gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= w;
		do @(posedge clk); while (req_stall);
		predicted = apply_command(w);
		outcome_q.push_back(typed ? want : predicted);
		n_words++;
		if (w.cmd == CMD_ALLOC && predicted.status == STAT_DONE)
			n_taken++;
		if (predicted.status == STAT_NOFREE)
			n_pool_empty++;
		if (predicted.status == STAT_RANGE)
			n_out_of_range++;
	endtask

	// sender holds off until every queued result word has come back
	task automatic drain_results();
		if (req_valid)
			req_valid <= 1'b0;
		while (outcome_q.size() != 0)
			@(posedge clk);
	endtask

	// register writes only with the block idle
	task automatic write_frame_count(logic [FC_W-1:0] value);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid       <= 1'b1;
		cfg_frame_count <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid      <= 1'b0;
		managed_frames  = value;
		n_settings++;
	endtask

	task automatic set_idling(idle_mode_t mode);
		case (mode)
			IDLE_NONE:     begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
			IDLE_SENDER:   begin sender_idle_pct = 75; rsp_stall_pct = 0;  end
			IDLE_RECEIVER: begin sender_idle_pct = 0;  rsp_stall_pct = 75; end
			default:       begin sender_idle_pct = 8;  rsp_stall_pct = 8;  end
		endcase
	endtask

	// ------------------------------------------------------------------
	// result side: random stall and in-order compare
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
	end

	always @(posedge clk) begin : result_check
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (outcome_q.size() == 0) begin
				$error("result word with nothing outstanding: %p", rsp);
				fail_count++;
			end else begin
				want = outcome_q.pop_front();
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp.status);
					fail_count++;
				end
				if (rsp.frame_number !== want.frame_number) begin
					$error("frame_number: expected %0d, got %0d",
					       want.frame_number, rsp.frame_number);
					fail_count++;
				end
				if (rsp.present !== want.present) begin
					$error("present: expected %0d, got %0d", want.present, rsp.present);
					fail_count++;
				end
				if (rsp.read_write !== want.read_write) begin
					$error("read_write: expected %0d, got %0d",
					       want.read_write, rsp.read_write);
					fail_count++;
				end
				if (rsp.user_mode !== want.user_mode) begin
					$error("user_mode: expected %0d, got %0d",
					       want.user_mode, rsp.user_mode);
					fail_count++;
				end
				if (rsp.frame_in_use !== want.frame_in_use) begin
					$error("frame_in_use: expected %0d, got %0d",
					       want.frame_in_use, rsp.frame_in_use);
					fail_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	initial begin
		script_row_t directed_script [$];

		// fresh bitmap, limit 1024
		directed_script.push_back(word_row(CMD_ALLOC, 22'd0, 10'd0, 1'b0, 1'b1, 1'b1,
			outcome(STAT_DONE, 10'd0, 1'b1, 1'b1, 1'b1, 1'b0)));
		directed_script.push_back(word_row(CMD_ALLOC, 22'h3FFFFF, 10'd0, 1'b1, 1'b0, 1'b1,
			outcome(STAT_DONE, 10'd1, 1'b1, 1'b0, 1'b0, 1'b0)));
		// page entry already holds a frame
		directed_script.push_back(word_row(CMD_ALLOC, 22'd0, 10'd1023, 1'b0, 1'b1, 1'b1,
			outcome(STAT_NOP, 10'd1023, 1'b0, 1'b0, 1'b0, 1'b0)));
		directed_script.push_back(word_row(CMD_TEST, 22'd0, 10'd0, 1'b0, 1'b0, 1'b1,
			outcome(STAT_DONE, 10'd0, 1'b0, 1'b0, 1'b0, 1'b1)));
		directed_script.push_back(word_row(CMD_TEST, 22'h3FFFFF, 10'h3FF, 1'b1, 1'b1, 1'b1,
			outcome(STAT_DONE, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0)));
		directed_script.push_back(word_row(CMD_MARK_USED, 22'h002000, 10'd0, 1'b0, 1'b0, 1'b1,
			outcome(STAT_DONE, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0)));
		// first fit steps over the frame marked by address
		directed_script.push_back(word_row(CMD_ALLOC, 22'd0, 10'd0, 1'b0, 1'b0, 1'b1,
			outcome(STAT_DONE, 10'd3, 1'b1, 1'b0, 1'b1, 1'b0)));
		// free of an empty entry
		directed_script.push_back(word_row(CMD_FREE, 22'h155555, 10'd0, 1'b1, 1'b1, 1'b1,
			outcome(STAT_NOP, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0)));
		directed_script.push_back(word_row(CMD_FREE, 22'd0, 10'd1, 1'b0, 1'b0, 1'b1,
			outcome(STAT_DONE, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0)));
		// hole left by the free is reused
		directed_script.push_back(word_row(CMD_ALLOC, 22'd0, 10'd0, 1'b1, 1'b1, 1'b0, '0));
		directed_script.push_back(word_row(CMD_MARK_FREE, 22'h003FFF, 10'd0, 1'b0, 1'b0, 1'b1,
			outcome(STAT_DONE, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0)));
		directed_script.push_back(word_row(CMD_TEST, 22'h003000, 10'd0, 1'b0, 1'b0, 1'b1,
			outcome(STAT_DONE, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0)));
		// undefined codes with every other field busy
		directed_script.push_back(word_row(3'd5, 22'h3FFFFF, 10'h3FF, 1'b1, 1'b1, 1'b1,
			outcome(STAT_NOP, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0)));
		directed_script.push_back(word_row(3'd7, 22'h2AAAAA, 10'h2AA, 1'b0, 1'b1, 1'b1,
			outcome(STAT_NOP, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0)));
		// top frame of the bitmap
		directed_script.push_back(word_row(CMD_MARK_USED, 22'h3FF000, 10'd0, 1'b0, 1'b0, 1'b1,
			outcome(STAT_DONE, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0)));
		directed_script.push_back(word_row(CMD_TEST, 22'h3FFFFF, 10'd0, 1'b0, 1'b0, 1'b1,
			outcome(STAT_DONE, 10'd0, 1'b0, 1'b0, 1'b0, 1'b1)));
		directed_script.push_back(word_row(CMD_FREE, 22'd0, 10'd1023, 1'b0, 1'b0, 1'b1,
			outcome(STAT_DONE, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0)));
		// two frames only, both taken: pool empty and range errors
		directed_script.push_back(cfg_row(11'd2));
		directed_script.push_back(word_row(CMD_ALLOC, 22'd0, 10'd0, 1'b0, 1'b1, 1'b1,
			outcome(STAT_NOFREE, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0)));
		directed_script.push_back(word_row(CMD_FREE, 22'd0, 10'd2, 1'b0, 1'b0, 1'b1,
			outcome(STAT_RANGE, 10'd2, 1'b0, 1'b0, 1'b0, 1'b0)));
		directed_script.push_back(word_row(CMD_TEST, 22'h002000, 10'd0, 1'b0, 1'b0, 1'b1,
			outcome(STAT_RANGE, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0)));
		directed_script.push_back(word_row(CMD_MARK_FREE, 22'h001000, 10'd0, 1'b0, 1'b0, 1'b1,
			outcome(STAT_DONE, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0)));
		directed_script.push_back(word_row(CMD_ALLOC, 22'd0, 10'd0, 1'b0, 1'b0, 1'b0, '0));
		// zero frames managed
		directed_script.push_back(cfg_row(11'd0));
		directed_script.push_back(word_row(CMD_ALLOC, 22'd0, 10'd0, 1'b1, 1'b1, 1'b1,
			outcome(STAT_NOFREE, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0)));
		directed_script.push_back(word_row(CMD_MARK_USED, 22'd0, 10'd0, 1'b0, 1'b0, 1'b1,
			outcome(STAT_RANGE, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0)));
		// register maximum saturates at the bitmap size
		directed_script.push_back(cfg_row(11'd2047));
		directed_script.push_back(word_row(CMD_TEST, 22'h3FFFFF, 10'd0, 1'b0, 1'b0, 1'b1,
			outcome(STAT_DONE, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0)));

		// reset once, at the start
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idling(IDLE_NONE);
		foreach (directed_script[i]) begin
			if (directed_script[i].kind == ROW_CFG)
				write_frame_count(directed_script[i].frame_count);
			else
				send_word(directed_script[i].w, directed_script[i].typed,
					  directed_script[i].want);
		end

		// random phases; the bitmap carries over between settings
		for (int p = 0; p < N_PHASES; p++) begin
			write_frame_count(PHASE_FRAMES[p]);
			set_idling(idle_mode_t'(p % 4));
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				// hold-off halfway through each phase
				if (n == WORDS_PER_PHASE / 2)
					drain_results();
				send_word(random_word(), 1'b0, '0);
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d command words under %0d frame_count settings", n_words, n_settings);
		$display("%0d frames handed out, %0d allocs on an empty pool, %0d out of range",
			 n_taken, n_pool_empty, n_out_of_range);
		if (fail_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
